>>> sv/bds_pkg.sv
// shared types and constants of the 2x2 box downsampler
package bds_pkg;

  localparam int PIX_W = 8;
  localparam int SUM_W = 9;
  localparam int CFG_W = 16;

  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pixel;
  } res_t;

endpackage

>>> sv/bds_cell.sv
// one cell of the line store chain, holding one pair sum
module bds_cell
  import bds_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic             tail,
  input  logic [SUM_W-1:0] din,
  input  logic [SUM_W-1:0] from_next,
  output logic [SUM_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= tail ? din : from_next;
    end
  end

endmodule

>>> sv/bds_line.sv
// line store: chain of cells with a movable entry point, read at cell zero
module bds_line
  import bds_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int IDX_W = 9
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [IDX_W-1:0] tail_idx,
  input  logic [SUM_W-1:0] din,
  output logic [SUM_W-1:0] dout
);

  logic [SUM_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SUM_W-1:0] from_next;
    logic             tail;

    if (i == DEPTH - 1) begin : g_top
      assign from_next = din;
    end else begin : g_mid
      assign from_next = q[i+1];
    end

    assign tail = (tail_idx == IDX_W'(i));

    bds_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .tail      (tail),
      .din       (din),
      .from_next (from_next),
      .q         (q[i])
    );
  end

  assign dout = q[0];

endmodule

>>> sv/bds_out.sv
// output register with skid stage
module bds_out
  import bds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  res_t             in_res,
  output logic             in_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [PIX_W-1:0] m_tdata,
  output logic             m_tlast
);

  logic out_valid;
  res_t out_res;
  logic skid_valid;
  res_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (in_valid) begin
        skid_res   <= in_res;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_res    <= skid_res;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_res <= in_res;
      end
    end
  end

  assign in_ready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.pixel;
  assign m_tlast  = out_res.last;

endmodule

>>> sv/box_downsample_2x2.sv
// top level of the streaming 2x2 box downsampler
//
//   channel  dir  handshake          contents
//   s        in   s_tvalid/s_tready  s_tdata[7:0] source pixel
//   m        out  m_tvalid/m_tready  m_tdata[7:0] mean pixel, m_tlast final pixel
//   cfg      in   cfg_wr_en          cfg_index register, cfg_data value
//
// one source pixel per cycle while s_tready is high; results are registered
// the line store is a chain of max_width/2 cells shifting once per column pair
// reset clears counters, output stage and sets width and height to 1
// a stalled output fills the skid stage, then s_tready drops until it drains
module box_downsample_2x2
  import bds_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // pixel
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // pixel_out
  output logic             m_tlast,   // last
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW         = (IDX_W + 1 > 11) ? IDX_W + 1 : 11;

  logic [10:0]      src_width;
  logic [15:0]      src_height;
  logic [7:0]       pair_first;
  logic [10:0]      column_count;
  logic [15:0]      row_count;

  logic [10:0]      w_eff;
  logic [15:0]      h_eff;
  logic [CW-1:0]    wo_raw;
  logic [CW-1:0]    wo;
  logic [CW-1:0]    wo_m1;
  logic [14:0]      ho;
  logic [15:0]      ho2;
  logic             w_one;
  logic             h_one;
  logic             accept;
  logic             have;
  logic [9:0]       idx;
  logic [SUM_W-1:0] pair_sum;
  logic             hit;
  logic             row_ok;
  logic             shift;
  logic [SUM_W-1:0] line_dout;
  logic [9:0]       sum_v;
  logic [9:0]       sum_h;
  logic             idx_last;
  logic             res_valid;
  res_t             res;
  logic             col_wrap;
  logic             row_wrap;

  assign w_eff  = (src_width == 11'd0) ? 11'd1 : src_width;
  assign h_eff  = (src_height == 16'd0) ? 16'd1 : src_height;
  assign w_one  = (w_eff == 11'd1);
  assign h_one  = (h_eff == 16'd1);
  assign wo_raw = (w_eff[10:1] == 10'd0) ? CW'(1) : CW'(w_eff[10:1]);
  assign wo     = (wo_raw > CW'(LINE_DEPTH)) ? CW'(LINE_DEPTH) : wo_raw;
  assign wo_m1  = wo - CW'(1);
  assign ho     = (h_eff[15:1] == 15'd0) ? 15'd1 : h_eff[15:1];
  assign ho2    = {ho, 1'b0};

  assign accept = s_tvalid && s_tready;

  always_comb begin
    have     = 1'b0;
    idx      = 10'd0;
    pair_sum = '0;
    if (w_one) begin
      have     = 1'b1;
      pair_sum = {s_tdata, 1'b0};
    end else if (column_count[0]) begin
      have     = 1'b1;
      idx      = column_count[10:1];
      pair_sum = {1'b0, pair_first} + {1'b0, s_tdata};
    end
  end

  assign hit       = have && (CW'(idx) < wo);
  assign row_ok    = (row_count < ho2);
  assign shift     = accept && hit && !h_one && row_ok;
  assign res_valid = accept && hit && (h_one || (row_ok && row_count[0]));
  assign idx_last  = (CW'(idx) == wo_m1);

  assign sum_v = {1'b0, line_dout} + {1'b0, pair_sum} + 10'd2;
  assign sum_h = {1'b0, pair_sum} + 10'd1;

  always_comb begin
    if (h_one) begin
      res.pixel = sum_h[8:1];
      res.last  = idx_last;
    end else begin
      res.pixel = sum_v[9:2];
      res.last  = idx_last && (row_count == ho2 - 16'd1);
    end
  end

  assign col_wrap = ({1'b0, column_count} + 12'd1) >= {1'b0, w_eff};
  assign row_wrap = ({1'b0, row_count} + 17'd1) >= {1'b0, h_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= 11'd1;
      src_height   <= 16'd1;
      pair_first   <= 8'd0;
      column_count <= 11'd0;
      row_count    <= 16'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[10:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[15:0];
      endcase
      pair_first   <= 8'd0;
      column_count <= 11'd0;
      row_count    <= 16'd0;
    end else if (accept) begin
      if (!w_one && !column_count[0]) begin
        pair_first <= s_tdata;
      end
      if (col_wrap) begin
        column_count <= 11'd0;
        row_count    <= row_wrap ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + 11'd1;
      end
    end
  end

  bds_line #(
    .DEPTH (LINE_DEPTH),
    .IDX_W (IDX_W)
  ) u_line (
    .clk      (clk),
    .shift    (shift),
    .tail_idx (wo_m1[IDX_W-1:0]),
    .din      (pair_sum),
    .dout     (line_dout)
  );

  bds_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_res   (res),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (column_count == 11'd0) && (row_count == 16'd0))
    else $error("configuration write did not restart the level");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    column_count < w_eff)
    else $error("column counter beyond source width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count < h_eff)
    else $error("row counter beyond source height");

endmodule

>>> test/box_downsample_2x2_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the streaming 2x2 box downsampler
module box_downsample_2x2_tb;
  import bds_pkg::*;

  localparam int LINE_CELLS   = 512;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 90;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {ST_PIXEL, ST_CONFIG} step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic             index;
    logic [CFG_W-1:0] value;
    logic             typed;
    res_t             want;
  } step_t;

  localparam res_t NO_RES = '{1'b0, 8'd0};

  // directed stimulus, pixel rows carry the pixel in value[7:0]
  step_t directed_tbl [34] = '{
    '{ST_PIXEL,  1'b0,           16'd0,     1'b1, '{1'b1, 8'd0}},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b1, '{1'b1, 8'd255}},
    '{ST_CONFIG, REG_SRC_WIDTH,  16'd2,     1'b0, NO_RES},
    '{ST_CONFIG, REG_SRC_HEIGHT, 16'd2,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b1, '{1'b1, 8'd255}},
    '{ST_PIXEL,  1'b0,           16'd0,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd1,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd0,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd1,     1'b1, '{1'b1, 8'd1}},
    // odd trailing column and row
    '{ST_CONFIG, REG_SRC_WIDTH,  16'd3,     1'b0, NO_RES},
    '{ST_CONFIG, REG_SRC_HEIGHT, 16'd3,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd0,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd17,    1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd200,   1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd3,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd90,    1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd91,    1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd255,   1'b0, NO_RES},
    // zero size, upper width bits ignored, then one-column and one-row levels
    '{ST_CONFIG, REG_SRC_WIDTH,  16'hF800,  1'b0, NO_RES},
    '{ST_CONFIG, REG_SRC_HEIGHT, 16'd0,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd128,   1'b1, '{1'b1, 8'd128}},
    '{ST_CONFIG, REG_SRC_WIDTH,  16'd1,     1'b0, NO_RES},
    '{ST_CONFIG, REG_SRC_HEIGHT, 16'd2,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd10,    1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd20,    1'b0, NO_RES},
    '{ST_CONFIG, REG_SRC_WIDTH,  16'd2,     1'b0, NO_RES},
    '{ST_CONFIG, REG_SRC_HEIGHT, 16'd1,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd7,     1'b0, NO_RES},
    '{ST_PIXEL,  1'b0,           16'd8,     1'b0, NO_RES}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'd0;  // pixel
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;         // pixel_out
  logic             m_tlast;         // last
  logic             cfg_wr_en = 1'b0;
  logic             cfg_index = REG_SRC_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [SUM_W-1:0] row_sums [LINE_CELLS];
  logic [7:0]       left_px;
  int               src_col;
  int               src_row;
  int               cfg_w;
  int               cfg_h;

  res_t mean_q [$];
  int   errors = 0;
  logic no_idle = 1'b0;

  box_downsample_2x2 u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic box_mean_predict(input logic [7:0] p, output logic has, output res_t r);
    int w, h, wo, ho, psum, idx;
    logic pair_done;
    w = (cfg_w == 0) ? 1 : cfg_w;
    h = (cfg_h == 0) ? 1 : cfg_h;
    wo = w / 2;
    ho = h / 2;
    if (wo < 1) wo = 1;
    if (wo > LINE_CELLS) wo = LINE_CELLS;
    if (ho < 1) ho = 1;
    psum = 0;
    idx = 0;
    pair_done = 1'b0;
    has = 1'b0;
    r = NO_RES;
    if (w == 1) begin
      psum = 2 * p;
      pair_done = 1'b1;
    end else if (src_col % 2 == 0) begin
      left_px = p;
    end else begin
      psum = left_px + p;
      idx = src_col / 2;
      pair_done = 1'b1;
    end
    if (pair_done && idx < wo) begin
      if (h == 1) begin
        r.pixel = 8'((2 * psum + 2) / 4);
        r.last = (idx == wo - 1);
        has = 1'b1;
      end else if (src_row < 2 * ho) begin
        if (src_row % 2 == 0) begin
          row_sums[idx] = SUM_W'(psum);
        end else begin
          r.pixel = 8'((int'(row_sums[idx]) + psum + 2) / 4);
          r.last = (idx == wo - 1) && (src_row == 2 * ho - 1);
          has = 1'b1;
        end
      end
    end
    if (src_col + 1 >= w) begin
      src_col = 0;
      src_row = (src_row + 1 >= h) ? 0 : src_row + 1;
    end else begin
      src_col = src_col + 1;
    end
  endtask

  task automatic send_pixel(input logic [7:0] p, input logic typed, input res_t want);
    logic has;
    res_t r;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 14) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = p;
    do @(posedge clk); while (!s_tready);
    box_mean_predict(p, has, r);
    if (has) mean_q.insert(mean_q.size(), typed ? want : r);
  endtask

  task automatic feed_pixels(input int n);
    for (int i = 0; i < n; i++) send_pixel(8'($urandom_range(255)), 1'b0, NO_RES);
  endtask

  // registers change only once the pipeline has drained
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (mean_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_data = '0;
    if (idx == REG_SRC_WIDTH) cfg_w = val & 16'h07FF;
    else cfg_h = val;
    left_px = 8'd0;
    src_col = 0;
    src_row = 0;
  endtask

  always @(negedge clk) begin
    m_tready = no_idle || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (mean_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected transaction: pixel_out %0d last %0b", m_tdata, m_tlast);
        errors++;
      end else begin
        exp_res = mean_q.pop_front();
        if (m_tdata !== exp_res.pixel || m_tlast !== exp_res.last) begin
          if (errors < MAX_REPORTS)
            $display("mismatch: pixel_out exp %0d got %0d, last exp %0b got %0b",
                     exp_res.pixel, m_tdata, exp_res.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int w, h, n, eff, done_items, k;
    logic [CFG_W-1:0] wv;
    for (int i = 0; i < LINE_CELLS; i++) row_sums[i] = '0;
    left_px = 8'd0;
    src_col = 0;
    src_row = 0;
    cfg_w = 1;
    cfg_h = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ST_CONFIG)
        write_reg(directed_tbl[i].index, directed_tbl[i].value);
      else
        send_pixel(directed_tbl[i].value[7:0], directed_tbl[i].typed, directed_tbl[i].want);
    end

    // width beyond the store with no idling, then tallest level
    no_idle = 1'b1;
    write_reg(REG_SRC_WIDTH, 16'hFFFF);
    write_reg(REG_SRC_HEIGHT, 16'd1);
    feed_pixels(1028);
    no_idle = 1'b0;
    write_reg(REG_SRC_WIDTH, 16'd3);
    write_reg(REG_SRC_HEIGHT, 16'hFFFF);
    feed_pixels(30);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       w = 0;
        1:       w = $urandom_range(13, 64);
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
        0:       h = $urandom_range(1) ? 0 : 65535;
        1:       h = $urandom_range(9, 20);
        default: h = $urandom_range(1, 8);
      endcase
      no_idle = ($urandom_range(5) == 0);
      if ($urandom_range(9) < 7) begin
        wv = {5'($urandom_range(31)), 11'(w)};
        write_reg(REG_SRC_WIDTH, wv);
      end
      if ($urandom_range(9) < 7) write_reg(REG_SRC_HEIGHT, 16'(h));
      eff = ((cfg_w == 0) ? 1 : cfg_w) * ((cfg_h == 0) ? 1 : cfg_h);
      if (eff > 300) n = $urandom_range(1, 300);
      else if ($urandom_range(4) == 0) n = $urandom_range(1, eff);
      else n = eff * $urandom_range(1, 2);
      if (n > RANDOM_ITEMS - done_items) n = RANDOM_ITEMS - done_items;
      feed_pixels(n);
      done_items += n;
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    k = 0;
    while (mean_q.size() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mean_q.size() != 0) begin
      if (errors < MAX_REPORTS) $display("missing transactions: %0d", mean_q.size());
      errors += mean_q.size();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/bds_pkg.sv
sv/bds_cell.sv
sv/bds_line.sv
sv/bds_out.sv
sv/box_downsample_2x2.sv
test/box_downsample_2x2_tb.sv
